// File: rtl/lzwh_pkg.sv
// LZW dictionary hash table: shared types, constants and codes.
// No dependencies; lzwh_hash and the top level import this package.
package lzwh_pkg;

    // Field widths fixed by the transaction format
    localparam int KIND_W     = 2;
    localparam int CHAR_W     = 8;
    localparam int CODE_W     = 12;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 14;
    localparam int MARK_W     = 2;
    localparam int SIZE_W     = 4;
    localparam int LG_W       = 5;
    localparam int HASH_W     = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LOG2  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_LIMIT = 1'b1;

    // Defaults for the top-level parameters
    localparam int TABLE_DEPTH_DEF = 8192;
    localparam int CODE_BITS_DEF   = 12;

    // Register reset values and limits
    localparam logic [SIZE_W-1:0]  SIZE_LOG2_RST  = 4'd13;
    localparam logic [COUNT_W-1:0] FILL_LIMIT_RST = 14'd6144;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = 14'h3FFF;
    localparam logic [LG_W-1:0]    MIN_LG         = 5'd4;

    // Hash multipliers
    localparam logic [HASH_W-1:0] HASH_CHAR_MUL = 32'd2726656;
    localparam logic [HASH_W-1:0] HASH_PREV_MUL = 32'd9931;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAD    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

    // Slot marks
    localparam logic [MARK_W-1:0] MARK_EMPTY  = 2'd0;
    localparam logic [MARK_W-1:0] MARK_NORMAL = 2'd1;
    localparam logic [MARK_W-1:0] MARK_PAD    = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [CHAR_W-1:0] char_value;
        logic [CODE_W-1:0]        prev_code;
        logic [CODE_W-1:0]        new_code;
    } t_in_item;

    typedef struct packed {
        logic [CODE_W-1:0]   found_code;
        logic [STATUS_W-1:0] status;
        logic                over_fill;
        logic [COUNT_W-1:0]  entry_count;
    } t_out_item;

endpackage

// File: rtl/lzwh_hash.sv
// Two-stage hash unit: registered products, then xor/add and mask.
// Depends on lzwh_pkg.
module lzwh_hash #(
    parameter int AW = 13
) (
    input  logic                              i_clk,
    input  logic signed [lzwh_pkg::CHAR_W-1:0] i_chr,
    input  logic [lzwh_pkg::CODE_W-1:0]       i_prev,
    input  logic [AW-1:0]                     i_mask,
    output logic [AW-1:0]                     o_pos
);
    import lzwh_pkg::*;

    logic [HASH_W-1:0] w_c32;
    logic [HASH_W-1:0] w_p32;
    logic [HASH_W-1:0] r_cprod;
    logic [HASH_W-1:0] r_pprod;
    logic [HASH_W-1:0] r_prev_d;
    logic [HASH_W-1:0] w_sum;
    logic [AW-1:0]     r_pos;

    assign w_c32 = {{(HASH_W-CHAR_W){i_chr[CHAR_W-1]}}, i_chr};
    assign w_p32 = {{(HASH_W-CODE_W){1'b0}}, i_prev};

    // stage 1: c*K1 + c and p*K2
    always_ff @(posedge i_clk) begin
        r_cprod  <= w_c32 * HASH_CHAR_MUL + w_c32;
        r_pprod  <= w_p32 * HASH_PREV_MUL;
        r_prev_d <= w_p32;
    end

    assign w_sum = (r_cprod ^ r_pprod) + r_prev_d;

    // stage 2: fold and mask to the active region
    always_ff @(posedge i_clk) begin
        r_pos <= w_sum[AW-1:0] & i_mask;
    end

    assign o_pos = r_pos;

endmodule

// File: rtl/lzwh_ram.sv
// Slot store: one write port, one read port with registered read data.
// Self-contained; no package dependencies.
module lzwh_ram #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13,
    parameter int DW    = 34
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/lzw_dictionary_hash_table.sv
// LZW string table in an open-addressed hash store with linear probing (top level).
// Depends on lzwh_pkg, lzwh_hash and lzwh_ram.
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+---------------------------
//  request  | i_in_valid   | o_in_stall   | i_in_item  (t_in_item)
//  result   | o_out_valid  | i_out_stall  | o_out_item (t_out_item)
//  config   | i_cfg_we     | (none)       | i_cfg_idx, i_cfg_data
//
// One request at a time. Insert/lookup: accept, then the hash states S_HASH1 and
//   S_HASH2, the probe loop over the slots visited and the result state; the probe
//   loop reads one slot per cycle from the single read port of the slot store.
// Clear: sweeps all TABLE_DEPTH slots, one per cycle, then the result state.
// Reset: a sweep of all TABLE_DEPTH slots empties the store; o_in_stall stays high
//   meanwhile (config writes are taken). A stalled result holds the block in its
//   result state until the output register frees up.
module lzw_dictionary_hash_table #(
    parameter int TABLE_DEPTH = lzwh_pkg::TABLE_DEPTH_DEF,
    parameter int CODE_BITS   = lzwh_pkg::CODE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  lzwh_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output lzwh_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_we,
    input  logic [lzwh_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lzwh_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import lzwh_pkg::*;

    localparam int AW     = $clog2(TABLE_DEPTH);
    // log2 of the largest power of two that fits the store
    localparam int LG_MAX = ((1 << AW) == TABLE_DEPTH) ? AW : AW - 1;
    localparam int CW     = (CODE_BITS < CODE_W) ? CODE_BITS : CODE_W;
    localparam int DW     = MARK_W + CHAR_W + 2 * CW;
    localparam int NW     = AW + 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_HASH1  = 3'd1;
    localparam logic [2:0] S_HASH2  = 3'd2;
    localparam logic [2:0] S_PROBE  = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;
    localparam logic [2:0] S_CLEAR  = 3'd5;

    // control
    logic [2:0]          r_state;
    logic                r_boot;
    logic [AW-1:0]       r_clr_addr;
    logic [NW-1:0]       r_issued;
    logic                r_chk_valid;
    logic [AW-1:0]       r_rd_addr;
    logic [AW-1:0]       r_chk_addr;
    logic [COUNT_W-1:0]  r_total;
    logic                r_out_valid;
    logic [SIZE_W-1:0]   r_size_log2;
    logic [COUNT_W-1:0]  r_fill_limit;

    // request payload
    logic [KIND_W-1:0]        r_kind;
    logic signed [CHAR_W-1:0] r_chr;
    logic [CW-1:0]            r_prev;
    logic [CW-1:0]            r_code;

    // result payload
    logic [CODE_W-1:0]   r_res_found;
    logic [STATUS_W-1:0] r_res_status;
    t_out_item           r_out_item;

    // derived size
    logic [LG_W-1:0]     w_lg;
    logic [AW-1:0]       w_mask;
    logic [NW-1:0]       w_nslots;

    // hash and store
    logic [AW-1:0]       w_pos;
    logic [CODE_W-1:0]   w_prev_ext;
    logic                w_re;
    logic [AW-1:0]       w_raddr;
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [DW-1:0]       w_wdata;
    logic [DW-1:0]       w_rdata;

    // probe decode
    logic [MARK_W-1:0]   w_mark;
    logic [CHAR_W-1:0]   w_schr;
    logic [CW-1:0]       w_sprev;
    logic [CW-1:0]       w_scode;
    logic                w_last;
    logic                w_match;
    logic                w_done;
    logic                w_place;
    logic [STATUS_W-1:0] w_status;
    logic [CODE_W-1:0]   w_found;

    logic                w_in_acc;
    logic                w_out_load;

    // ---------------------------------------------------------------
    // Active region: size_log2 clamped to [4, LG_MAX]
    // ---------------------------------------------------------------
    always_comb begin
        w_lg = {1'b0, r_size_log2};
        if (w_lg < MIN_LG) begin
            w_lg = MIN_LG;
        end else if (w_lg > LG_W'(LG_MAX)) begin
            w_lg = LG_W'(LG_MAX);
        end
        for (int i = 0; i < AW; i++) begin
            w_mask[i] = (LG_W'(i) < w_lg);
        end
        w_nslots = NW'(1) << w_lg;
    end

    // ---------------------------------------------------------------
    // Hash unit; fed from the held request, result valid in S_PROBE
    // ---------------------------------------------------------------
    assign w_prev_ext = CODE_W'(r_prev);

    lzwh_hash #(
        .AW (AW)
    ) u_hash (
        .i_clk  (i_clk),
        .i_chr  (r_chr),
        .i_prev (w_prev_ext),
        .i_mask (w_mask),
        .o_pos  (w_pos)
    );

    // ---------------------------------------------------------------
    // Probe loop: issue one read per cycle, check the slot read last cycle
    // ---------------------------------------------------------------
    assign w_re    = (r_state == S_PROBE) && (r_issued != w_nslots);
    assign w_raddr = (r_issued == '0) ? w_pos : r_rd_addr;

    assign {w_mark, w_schr, w_sprev, w_scode} = w_rdata;

    assign w_last  = (r_issued == w_nslots);
    assign w_match = (w_mark == MARK_NORMAL) && (w_sprev == r_prev)
                     && (w_schr == r_chr);

    always_comb begin
        w_done   = 1'b0;
        w_place  = 1'b0;
        w_status = ST_OK;
        w_found  = '0;
        if ((r_state == S_PROBE) && r_chk_valid) begin
            if (r_kind == KIND_LOOKUP) begin
                priority if (w_mark == MARK_EMPTY) begin
                    w_done   = 1'b1;
                    w_status = ST_NOTFOUND;
                end else if (w_match) begin
                    w_done   = 1'b1;
                    w_found  = CODE_W'(w_scode);
                end else if (w_last) begin
                    w_done   = 1'b1;
                    w_status = ST_NOTFOUND;
                end else begin
                    w_done   = 1'b0;
                end
            end else begin
                priority if (w_mark == MARK_EMPTY) begin
                    w_done  = 1'b1;
                    w_place = 1'b1;
                end else if (w_last) begin
                    w_done   = 1'b1;
                    w_status = ST_FULL;
                end else begin
                    w_done   = 1'b0;
                end
            end
        end
    end

    // store write: clearing sweep or a placed insert or pad
    always_comb begin
        if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = '0;
        end else begin
            w_we    = w_place;
            w_waddr = r_chk_addr;
            w_wdata = {((r_kind == KIND_INSERT) ? MARK_NORMAL : MARK_PAD),
                       r_chr, r_prev, r_code};
        end
    end

    lzwh_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .DW    (DW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // ---------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------
    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_out_load = (r_state == S_RESULT) && (!r_out_valid || !i_out_stall);

    // ---------------------------------------------------------------
    // Sequencer and control registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_boot       <= 1'b1;
            r_clr_addr   <= '0;
            r_issued     <= '0;
            r_chk_valid  <= 1'b0;
            r_total      <= '0;
            r_out_valid  <= 1'b0;
            r_size_log2  <= SIZE_LOG2_RST;
            r_fill_limit <= FILL_LIMIT_RST;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SIZE_LOG2:  r_size_log2  <= i_cfg_data[SIZE_W-1:0];
                    CFG_FILL_LIMIT: r_fill_limit <= i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_in_item.kind == KIND_CLEAR) begin
                            r_state    <= S_CLEAR;
                            r_clr_addr <= '0;
                        end else begin
                            r_state <= S_HASH1;
                        end
                    end
                end
                S_HASH1: r_state <= S_HASH2;
                S_HASH2: begin
                    r_state     <= S_PROBE;
                    r_issued    <= '0;
                    r_chk_valid <= 1'b0;
                end
                S_PROBE: begin
                    if (w_re) begin
                        r_issued <= r_issued + NW'(1);
                    end
                    r_chk_valid <= w_re;
                    if (w_done) begin
                        r_state <= S_RESULT;
                        if (w_place && (r_total != COUNT_MAX)) begin
                            r_total <= r_total + COUNT_W'(1);
                        end
                    end
                end
                S_RESULT: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(TABLE_DEPTH - 1)) begin
                        r_total <= '0;
                        r_boot  <= 1'b0;
                        r_state <= r_boot ? S_IDLE : S_RESULT;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_kind <= i_in_item.kind;
            r_chr  <= i_in_item.char_value;
            r_prev <= i_in_item.prev_code[CW-1:0];
            r_code <= i_in_item.new_code[CW-1:0];
        end

        if (r_state == S_PROBE) begin
            r_rd_addr  <= (w_raddr + AW'(1)) & w_mask;
            r_chk_addr <= w_raddr;
        end

        if (w_done) begin
            r_res_found  <= w_found;
            r_res_status <= w_status;
        end else if ((r_state == S_CLEAR) && (r_clr_addr == AW'(TABLE_DEPTH - 1))) begin
            r_res_found  <= '0;
            r_res_status <= ST_OK;
        end

        // count is already final in the result state
        if (w_out_load) begin
            r_out_item.found_code  <= r_res_found;
            r_out_item.status      <= r_res_status;
            r_out_item.over_fill   <= (r_total > r_fill_limit);
            r_out_item.entry_count <= r_total;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
